// ===== hw/rtl/forward_moving_average_filter_macros.svh =====
// Assertion helpers used by the filter front end (fmaf_front).
// Both expect signals named clock and reset in the enclosing module.
`ifndef FORWARD_MOVING_AVERAGE_FILTER_MACROS_SVH
`define FORWARD_MOVING_AVERAGE_FILTER_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define FMAF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define FMAF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/fmaf_pkg.sv =====
package fmaf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int WIN_W    = 7;
   localparam int RECIP_W  = 17;
   localparam int SUM_W    = 23;
   localparam int AVG_W    = 16;
   localparam int BIN_W    = 12;
   localparam int PROD_W   = SUM_W + RECIP_W + 1;
   localparam int FRAC_W   = 16;
   localparam int QUOT_W   = PROD_W - FRAC_W;

   localparam int DEF_MAX_WINDOW    = 64;
   localparam int DEF_MAX_TRACE_LEN = 4096;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = RECIP_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_RECIPROCAL    = 1'b1
   } csr_index_type;

   localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(4);
   localparam logic [RECIP_W-1:0] RECIP_RESET  = RECIP_W'(16384);

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [BIN_W-1:0]        bin;
      logic                    last;
   } sum_item_type;

endpackage

// ===== hw/rtl/fmaf_interfaces.sv =====
interface fmaf_req_if;
   import fmaf_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       trace_end;

   modport source (output valid, output sample, output trace_end, input ready);
   modport sink   (input valid, input sample, input trace_end, output ready);
endinterface

interface fmaf_rsp_if;
   import fmaf_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [AVG_W-1:0] average;
   logic [BIN_W-1:0]        bin_index;
   logic                    trace_end_res;

   modport source (output valid, output average, output bin_index, output trace_end_res,
                   input ready);
   modport sink   (input valid, input average, input bin_index, input trace_end_res,
                   output ready);
endinterface

interface fmaf_csr_if;
   import fmaf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/forward_moving_average_filter.sv =====
// Boxcar moving average over a ring delay line held in one RAM.
// Each result passes registers for the RAM read, sum update, multiply and
// saturate in turn; one item is accepted per cycle unless the response stalls.
// The running sum is the only loop, so items stream back to back unless the output stalls.
// Reset clears pointer, count, sum, pipeline valids and restores the registers
// (window 4, reciprocal 16384); the delay RAM is not cleared.
module forward_moving_average_filter #(
   parameter int MAX_WINDOW    = fmaf_pkg::DEF_MAX_WINDOW,
   parameter int MAX_TRACE_LEN = fmaf_pkg::DEF_MAX_TRACE_LEN
) (
   input logic        clock,
   input logic        reset,
   fmaf_req_if.sink   req_ch,
   fmaf_rsp_if.source rsp_ch,
   fmaf_csr_if.sink   csr_ch
);
   import fmaf_pkg::*;

   logic [WIN_W-1:0]   window_ff, window_in;
   logic [RECIP_W-1:0] recip_ff, recip_in;

   logic         sum_valid, sum_ready;
   sum_item_type sum_item;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      window_in = window_ff;
      recip_in  = recip_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_WINDOW_LENGTH: window_in = csr_ch.data[WIN_W-1:0];
            CSR_RECIPROCAL:    recip_in  = csr_ch.data[RECIP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         recip_ff  <= RECIP_RESET;
      end else begin
         window_ff <= window_in;
         recip_ff  <= recip_in;
      end
   end

   fmaf_front #(
      .MAX_WINDOW    (MAX_WINDOW),
      .MAX_TRACE_LEN (MAX_TRACE_LEN)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .window_length (window_ff),
      .out_valid     (sum_valid),
      .out_ready     (sum_ready),
      .out_item      (sum_item)
   );

   fmaf_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (sum_valid),
      .in_ready       (sum_ready),
      .in_item        (sum_item),
      .reciprocal_q16 (recip_ff),
      .rsp_ch         (rsp_ch)
   );
endmodule

// ===== hw/rtl/fmaf_delay_ram.sv =====
module fmaf_delay_ram #(
   parameter int DEPTH = fmaf_pkg::DEF_MAX_WINDOW,
   parameter int WIDTH = fmaf_pkg::SAMPLE_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-during-write to the same entry returns the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/fmaf_front.sv =====
`include "forward_moving_average_filter_macros.svh"

module fmaf_front #(
   parameter int MAX_WINDOW    = fmaf_pkg::DEF_MAX_WINDOW,
   parameter int MAX_TRACE_LEN = fmaf_pkg::DEF_MAX_TRACE_LEN
) (
   input  logic                        clock,
   input  logic                        reset,
   fmaf_req_if.sink                    req_ch,
   input  logic [fmaf_pkg::WIN_W-1:0]  window_length,
   output logic                        out_valid,
   input  logic                        out_ready,
   output fmaf_pkg::sum_item_type      out_item
);
   import fmaf_pkg::*;

   localparam int AW = $clog2(MAX_WINDOW);
   localparam int CW = $clog2(MAX_TRACE_LEN);

   logic [AW-1:0] wp_ff, wp_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;

   logic                       s1_v_ff, s1_v_in;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic                       s1_last_ff, s1_active_ff, s1_sub_ff, s1_emit_ff;
   logic [BIN_W-1:0]           s1_bin_ff;

   logic         s2_v_ff, s2_v_in;
   sum_item_type s2_item_ff, s2_item_in;

   logic [WIN_W-1:0] w_eff;
   logic [31:0]      w32, pos32, wp32, idx32, bin32;
   logic             active, sub, emit, accept, s2_free, adv1;
   logic [AW-1:0]    rd_addr;
   logic [SAMPLE_W-1:0] old_sample;
   logic [SUM_W-1:0] sample_ext, old_ext, sum_new;

   // window above the delay line depth acts as the full depth
   assign w_eff  = (32'(window_length) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : window_length;
   assign active = w_eff >= WIN_W'(2);
   assign w32    = 32'(w_eff);
   assign pos32  = 32'(count_ff);
   assign wp32   = 32'(wp_ff);
   assign sub    = pos32 >= w32;
   assign emit   = active && (pos32 + 32'd1 >= w32);
   assign bin32  = pos32 - w32 + 32'd1;
   assign idx32  = (wp32 >= w32) ? (wp32 - w32) : (wp32 + 32'(MAX_WINDOW) - w32);
   assign rd_addr = idx32[AW-1:0];

   assign s2_free      = !s2_v_ff || out_ready;
   assign req_ch.ready = !s1_v_ff || s2_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign adv1         = s1_v_ff && s2_free;

   fmaf_delay_ram #(
      .DEPTH (MAX_WINDOW),
      .WIDTH (SAMPLE_W)
   ) u_delay (
      .clock   (clock),
      .wr_en   (accept && active),
      .wr_addr (wp_ff),
      .wr_data (req_ch.sample),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (old_sample)
   );

   assign sample_ext = {{(SUM_W-SAMPLE_W){s1_sample_ff[SAMPLE_W-1]}}, s1_sample_ff};
   assign old_ext    = {{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};

   always_comb begin
      wp_in    = wp_ff;
      count_in = count_ff;
      if (accept && active) begin
         wp_in = (wp32 == 32'(MAX_WINDOW - 1)) ? '0 : wp_ff + AW'(1);
         if (pos32 < 32'(MAX_TRACE_LEN - 1)) begin
            count_in = count_ff + CW'(1);
         end
      end
      if (accept && req_ch.trace_end) begin
         count_in = '0;
      end
   end

   always_comb begin
      sum_new = sum_ff;
      if (s1_active_ff) begin
         sum_new = sum_ff + sample_ext - (s1_sub_ff ? old_ext : '0);
      end
      sum_in = sum_ff;
      if (adv1) begin
         sum_in = s1_last_ff ? '0 : sum_new;
      end
   end

   always_comb begin
      s1_v_in = s1_v_ff;
      if (req_ch.ready) begin
         s1_v_in = accept;
      end
      s2_v_in         = s2_v_ff;
      s2_item_in      = s2_item_ff;
      if (s2_free) begin
         s2_v_in         = adv1 && s1_emit_ff;
         s2_item_in.sum  = $signed(sum_new);
         s2_item_in.bin  = s1_bin_ff;
         s2_item_in.last = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
      end else begin
         wp_ff    <= wp_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_ch.sample;
         s1_last_ff   <= req_ch.trace_end;
         s1_active_ff <= active;
         s1_sub_ff    <= sub;
         s1_emit_ff   <= emit;
         s1_bin_ff    <= bin32[BIN_W-1:0];
      end
      s2_item_ff <= s2_item_in;
   end

   assign out_valid = s2_v_ff;
   assign out_item  = s2_item_ff;

   `FMAF_ASSERT_NOW(a_wp_range, 1'b1, 32'(wp_ff) < MAX_WINDOW, "write pointer past depth")
   `FMAF_ASSERT_NOW(a_count_sat, 1'b1, 32'(count_ff) < MAX_TRACE_LEN, "sample count overran")
   `FMAF_ASSERT_NEXT(a_end_clears, accept && req_ch.trace_end, count_ff == '0,
      "trace end did not clear count")
   `FMAF_ASSERT_NEXT(a_s2_hold, s2_v_ff && !out_ready, s2_v_ff && $stable(s2_item_ff),
      "stalled sum item changed")
endmodule

// ===== hw/rtl/fmaf_scale.sv =====
module fmaf_scale (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  fmaf_pkg::sum_item_type       in_item,
   input  logic [fmaf_pkg::RECIP_W-1:0] reciprocal_q16,
   fmaf_rsp_if.source                   rsp_ch
);
   import fmaf_pkg::*;

   logic                     p_v_ff, p_v_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic [BIN_W-1:0]         p_bin_ff;
   logic                     p_last_ff;

   logic                    o_v_ff, o_v_in;
   logic signed [AVG_W-1:0] o_avg_ff, o_avg_in;
   logic [BIN_W-1:0]        o_bin_ff;
   logic                    o_last_ff;

   logic out_free, p_free;
   logic signed [QUOT_W-1:0] quot;
   logic [QUOT_W-AVG_W:0]    quot_hi;

   assign out_free = !o_v_ff || rsp_ch.ready;
   assign p_free   = !p_v_ff || out_free;
   assign in_ready = p_free;

   // arithmetic shift gives the floor of the Q16 product
   assign quot    = prod_ff[PROD_W-1:FRAC_W];
   assign quot_hi = quot[QUOT_W-1:AVG_W-1];

   always_comb begin
      if ((&quot_hi) || !(|quot_hi)) begin
         o_avg_in = quot[AVG_W-1:0];
      end else if (quot[QUOT_W-1]) begin
         o_avg_in = {1'b1, {(AVG_W-1){1'b0}}};
      end else begin
         o_avg_in = {1'b0, {(AVG_W-1){1'b1}}};
      end
      p_v_in = p_free ? in_valid : p_v_ff;
      o_v_in = out_free ? p_v_ff : o_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         p_v_ff <= p_v_in;
         o_v_ff <= o_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p_free && in_valid) begin
         prod_ff   <= in_item.sum * $signed({1'b0, reciprocal_q16});
         p_bin_ff  <= in_item.bin;
         p_last_ff <= in_item.last;
      end
      if (out_free && p_v_ff) begin
         o_avg_ff  <= o_avg_in;
         o_bin_ff  <= p_bin_ff;
         o_last_ff <= p_last_ff;
      end
   end

   assign rsp_ch.valid         = o_v_ff;
   assign rsp_ch.average       = o_avg_ff;
   assign rsp_ch.bin_index     = o_bin_ff;
   assign rsp_ch.trace_end_res = o_last_ff;
endmodule
